// ===== rtl/core/rk4_pkg.sv =====
// rk4_pkg: shared widths, constants, payload types and rounding helpers
package rk4_pkg;

   localparam int FRAC_BITS = 24;
   localparam int DATA_W    = 32;
   localparam int STEP_W    = 31;
   localparam int SLOPE_W   = 31;
   localparam int SQ_W      = 64;
   localparam int EXT_W     = DATA_W + 2;
   localparam int PROD_W    = SLOPE_W + STEP_W;

   // weighted slope sum and its division by six through a reciprocal
   localparam int SUM_W      = 34;
   localparam int SUM_LO_W   = SUM_W / 2;
   localparam int SUM_HI_W   = SUM_W - SUM_LO_W;
   localparam int SUM_SHIFT  = SUM_W + 3;
   localparam int SUM_RCP_W  = SUM_SHIFT - 2;
   localparam int SUM_FULL_W = SUM_W + SUM_RCP_W;
   localparam int QUO_W      = 31;
   localparam int REM_W      = 3;
   localparam int REM_PROD_W = STEP_W + REM_W;

   // fractional part of the increment, divided by six after the shift
   localparam int NUM_W    = 35;
   localparam int U_W      = NUM_W - FRAC_BITS;
   localparam int U_SHIFT  = U_W + 3;
   localparam int U_RCP_W  = U_SHIFT - 2;
   localparam int U_PROD_W = U_W + U_RCP_W;
   localparam int QQ_W     = U_PROD_W - U_SHIFT;
   localparam int AH_W     = PROD_W - FRAC_BITS;
   localparam int INC_W    = AH_W + 1;

   localparam logic [63:0] STEP_RESET_FULL = ((64'd1 << FRAC_BITS) + 64'd2) / 64'd5;
   localparam logic [STEP_W-1:0] STEP_RESET = STEP_RESET_FULL[STEP_W-1:0];

   localparam logic [63:0] SUM_RCP_FULL = ((64'd1 << SUM_SHIFT) + 64'd5) / 64'd6;
   localparam logic [SUM_RCP_W-1:0] SUM_RCP = SUM_RCP_FULL[SUM_RCP_W-1:0];

   localparam logic [63:0] U_RCP_FULL = ((64'd1 << U_SHIFT) + 64'd5) / 64'd6;
   localparam logic [U_RCP_W-1:0] U_RCP = U_RCP_FULL[U_RCP_W-1:0];

   localparam logic [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [EXT_W-1:0] EXT_MAX = $signed({2'b00, DATA_MAX});
   localparam logic signed [EXT_W-1:0] EXT_MIN = $signed({2'b11, DATA_MIN});

   typedef struct packed {
      logic signed [DATA_W-1:0] x_now;
      logic signed [DATA_W-1:0] y_now;
   } req_payload_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] x_next;
      logic signed [DATA_W-1:0] y_next;
      logic                     overflow;
   } rsp_payload_type;

   // per-point context that rides along the pipeline
   typedef struct packed {
      logic signed [DATA_W-1:0] x_mid;
      logic signed [DATA_W-1:0] x_end;
      logic signed [DATA_W-1:0] y_base;
      logic [SUM_W-1:0]         acc;
      logic                     ovf;
   } ctx_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] x_end;
      logic signed [DATA_W-1:0] y_base;
      logic                     ovf;
   } tail_type;

   typedef struct packed {
      logic half_step;
      logic double_weight;
   } scale_mode_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              sat;
   } sat_type;

   function automatic sat_type clamp_ext(input logic signed [EXT_W-1:0] v);
      sat_type res;
      if (v > EXT_MAX) begin
         res.value = DATA_MAX;
         res.sat   = 1'b1;
      end else if (v < EXT_MIN) begin
         res.value = DATA_MIN;
         res.sat   = 1'b1;
      end else begin
         res.value = v[DATA_W-1:0];
         res.sat   = 1'b0;
      end
      return res;
   endfunction

   // round half up to FRAC_BITS fraction bits, then clamp to the upper limit
   function automatic sat_type round_clamp(input logic [SQ_W-1:0] v);
      logic [SQ_W-1:0] rounded;
      sat_type         res;
      rounded = (v + (SQ_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      if (rounded > SQ_W'(DATA_MAX)) begin
         res.value = DATA_MAX;
         res.sat   = 1'b1;
      end else begin
         res.value = rounded[DATA_W-1:0];
         res.sat   = 1'b0;
      end
      return res;
   endfunction

endpackage

// ===== rtl/core/rk4_slope.sv =====
// rk4_slope: two-stage evaluation of f(x, y) = x^2 + y^2 with saturation
module rk4_slope (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  rk4_pkg::ctx_type                 in_ctx,
   input  logic signed [rk4_pkg::DATA_W-1:0] x_arg,
   input  logic signed [rk4_pkg::DATA_W-1:0] y_arg,
   output logic                             out_valid,
   output rk4_pkg::ctx_type                 out_ctx,
   output logic [rk4_pkg::SLOPE_W-1:0]      slope_m
);
   import rk4_pkg::*;

   logic                   sq_valid_ff, sq_valid_in;
   ctx_type                sq_ctx_ff, sq_ctx_in;
   logic signed [SQ_W-1:0] sq_x_ff, sq_x_in;
   logic signed [SQ_W-1:0] sq_y_ff, sq_y_in;
   logic                   m_valid_ff, m_valid_in;
   ctx_type                m_ctx_ff, m_ctx_in;
   logic [SLOPE_W-1:0]     m_ff, m_in;
   sat_type                rx, ry;
   logic [DATA_W:0]        m_sum;
   logic                   m_sat;

   // signed squares are never negative, so no magnitude step is needed
   always_comb begin
      sq_valid_in = in_valid;
      sq_ctx_in   = in_ctx;
      sq_x_in     = x_arg * x_arg;
      sq_y_in     = y_arg * y_arg;
   end

   always_comb begin
      rx         = round_clamp($unsigned(sq_x_ff));
      ry         = round_clamp($unsigned(sq_y_ff));
      m_sum      = {1'b0, rx.value} + {1'b0, ry.value};
      m_sat      = (m_sum[DATA_W:DATA_W-1] != 2'b00);
      m_in       = m_sat ? DATA_MAX[SLOPE_W-1:0] : m_sum[SLOPE_W-1:0];
      m_valid_in = sq_valid_ff;
      m_ctx_in   = sq_ctx_ff;
      m_ctx_in.ovf = sq_ctx_ff.ovf | rx.sat | ry.sat | m_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
         m_valid_ff  <= 1'b0;
      end else begin
         sq_valid_ff <= sq_valid_in;
         m_valid_ff  <= m_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_ctx_ff <= sq_ctx_in;
      sq_x_ff   <= sq_x_in;
      sq_y_ff   <= sq_y_in;
      m_ctx_ff  <= m_ctx_in;
      m_ff      <= m_in;
   end

   assign out_valid = m_valid_ff;
   assign out_ctx   = m_ctx_ff;
   assign slope_m   = m_ff;

endmodule

// ===== rtl/core/rk4_scale.sv =====
// rk4_scale: slope times step, rounded, added to y; also accumulates the weighted slope
module rk4_scale (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  rk4_pkg::ctx_type                 in_ctx,
   input  logic [rk4_pkg::SLOPE_W-1:0]      slope_m,
   input  logic [rk4_pkg::STEP_W-1:0]       step_size,
   input  rk4_pkg::scale_mode_type          mode,
   output logic                             out_valid,
   output rk4_pkg::ctx_type                 out_ctx,
   output logic signed [rk4_pkg::DATA_W-1:0] y_arg
);
   import rk4_pkg::*;

   logic                     p_valid_ff, p_valid_in;
   ctx_type                  p_ctx_ff, p_ctx_in;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic                     y_valid_ff, y_valid_in;
   ctx_type                  y_ctx_ff, y_ctx_in;
   logic signed [DATA_W-1:0] y_ff, y_in;
   logic [PROD_W-1:0]        scaled;
   sat_type                  t_res;
   sat_type                  y_res;
   logic signed [EXT_W-1:0]  y_wide;

   always_comb begin
      p_valid_in = in_valid;
      prod_in    = slope_m * step_size;
      p_ctx_in   = in_ctx;
      p_ctx_in.acc = in_ctx.acc + (mode.double_weight ? SUM_W'({slope_m, 1'b0})
                                                      : SUM_W'(slope_m));
   end

   // rounding at one extra fraction bit equals rounding the halved product
   always_comb begin
      scaled     = mode.half_step ? (prod_ff >> 1) : prod_ff;
      t_res      = round_clamp(SQ_W'(scaled));
      y_wide     = EXT_W'(p_ctx_ff.y_base) + $signed(EXT_W'(t_res.value));
      y_res      = clamp_ext(y_wide);
      y_in       = $signed(y_res.value);
      y_valid_in = p_valid_ff;
      y_ctx_in   = p_ctx_ff;
      y_ctx_in.ovf = p_ctx_ff.ovf | t_res.sat | y_res.sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         y_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= p_valid_in;
         y_valid_ff <= y_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ctx_ff <= p_ctx_in;
      prod_ff  <= prod_in;
      y_ctx_ff <= y_ctx_in;
      y_ff     <= y_in;
   end

   assign out_valid = y_valid_ff;
   assign out_ctx   = y_ctx_ff;
   assign y_arg     = y_ff;

endmodule

// ===== rtl/core/rk4_incr.sv =====
// rk4_incr: final increment h*(m1+2m2+2m3+m4)/6, rounded, and the saturated new y
module rk4_incr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  rk4_pkg::ctx_type            in_ctx,
   input  logic [rk4_pkg::SLOPE_W-1:0] slope_m,
   input  logic [rk4_pkg::STEP_W-1:0]  step_size,
   output logic                        out_valid,
   output rk4_pkg::rsp_payload_type    out_payload
);
   import rk4_pkg::*;

   localparam int TAIL_N  = 8;
   localparam int VALID_N = TAIL_N + 1;
   localparam logic signed [INC_W:0] WIDE_MAX =
      {{(INC_W+1-DATA_W){1'b0}}, DATA_MAX};

   logic [VALID_N-1:0]        valid_ff, valid_in;
   tail_type                  tail_ff [TAIL_N];
   tail_type                  tail_in [TAIL_N];

   logic [SUM_W-1:0]          sum_ff, sum_in;
   logic [SUM_LO_W+SUM_RCP_W-1:0] pp_lo_ff, pp_lo_in;
   logic [SUM_HI_W+SUM_RCP_W-1:0] pp_hi_ff, pp_hi_in;
   logic [REM_W-1:0]          sum_lsb2_ff, sum_lsb2_in;
   logic [REM_W-1:0]          sum_lsb3_ff, sum_lsb3_in;
   logic [SUM_FULL_W-1:0]     pp_full;
   logic [QUO_W-1:0]          quo_ff, quo_in;
   logic [PROD_W-1:0]         a_ff, a_in;
   logic [REM_W-1:0]          six_q;
   logic [REM_W-1:0]          rem_ff, rem_in;
   logic [REM_PROD_W-1:0]     b_ff, b_in;
   logic [NUM_W-1:0]          t6_ff, t6_in;
   logic [AH_W-1:0]           ah5_ff, ah5_in;
   logic [NUM_W-1:0]          num;
   logic [U_W-1:0]            u_ff, u_in;
   logic [AH_W-1:0]           ah6_ff, ah6_in;
   logic [U_PROD_W-1:0]       pr_ff, pr_in;
   logic [AH_W-1:0]           ah7_ff, ah7_in;
   logic [QQ_W-1:0]           qq;
   logic [INC_W-1:0]          inc_ff, inc_in;
   logic signed [INC_W:0]     y_wide;
   logic                      y_sat;
   rsp_payload_type           out_ff, out_in;

   always_comb begin
      valid_in = {valid_ff[VALID_N-2:0], in_valid};
      tail_in[0].x_end  = in_ctx.x_end;
      tail_in[0].y_base = in_ctx.y_base;
      tail_in[0].ovf    = in_ctx.ovf;
      for (int k = 1; k < TAIL_N; k++) begin
         tail_in[k] = tail_ff[k-1];
      end
   end

   // weighted sum, then its quotient by six through the reciprocal in two halves
   always_comb begin
      sum_in      = in_ctx.acc + SUM_W'(slope_m);
      pp_lo_in    = sum_ff[SUM_LO_W-1:0] * SUM_RCP;
      pp_hi_in    = sum_ff[SUM_W-1:SUM_LO_W] * SUM_RCP;
      sum_lsb2_in = sum_ff[REM_W-1:0];
      pp_full     = (SUM_FULL_W'(pp_hi_ff) << SUM_LO_W) + SUM_FULL_W'(pp_lo_ff);
      quo_in      = pp_full[SUM_SHIFT +: QUO_W];
      sum_lsb3_in = sum_lsb2_ff;
   end

   // remainder below six needs only the low bits of sum - 6q
   always_comb begin
      a_in   = quo_ff * step_size;
      six_q  = {quo_ff[0], 2'b00} + {quo_ff[1:0], 1'b0};
      rem_in = sum_lsb3_ff - six_q;
   end

   always_comb begin
      b_in   = rem_ff * step_size;
      t6_in  = (NUM_W'(a_ff[FRAC_BITS-1:0]) << 2) + (NUM_W'(a_ff[FRAC_BITS-1:0]) << 1)
             + (NUM_W'(3) << FRAC_BITS);
      ah5_in = a_ff[PROD_W-1:FRAC_BITS];
      num    = t6_ff + NUM_W'(b_ff);
      u_in   = num[NUM_W-1:FRAC_BITS];
      ah6_in = ah5_ff;
      pr_in  = u_ff * U_RCP;
      ah7_in = ah6_ff;
      qq     = pr_ff[U_PROD_W-1:U_SHIFT];
      inc_in = INC_W'(ah7_ff) + INC_W'(qq);
   end

   // increment is never negative, only the upper limit can be hit
   always_comb begin
      y_wide = (INC_W+1)'(tail_ff[TAIL_N-1].y_base) + $signed({1'b0, inc_ff});
      y_sat  = (y_wide > WIDE_MAX);
      out_in.x_next   = tail_ff[TAIL_N-1].x_end;
      out_in.y_next   = y_sat ? $signed(DATA_MAX) : y_wide[DATA_W-1:0];
      out_in.overflow = tail_ff[TAIL_N-1].ovf | y_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < TAIL_N; k++) begin
         tail_ff[k] <= tail_in[k];
      end
      sum_ff      <= sum_in;
      pp_lo_ff    <= pp_lo_in;
      pp_hi_ff    <= pp_hi_in;
      sum_lsb2_ff <= sum_lsb2_in;
      sum_lsb3_ff <= sum_lsb3_in;
      quo_ff      <= quo_in;
      a_ff        <= a_in;
      rem_ff      <= rem_in;
      b_ff        <= b_in;
      t6_ff       <= t6_in;
      ah5_ff      <= ah5_in;
      u_ff        <= u_in;
      ah6_ff      <= ah6_in;
      pr_ff       <= pr_in;
      ah7_ff      <= ah7_in;
      inc_ff      <= inc_in;
      out_ff      <= out_in;
   end

   assign out_valid   = valid_ff[VALID_N-1];
   assign out_payload = out_ff;

endmodule

// ===== rtl/core/rk4_step_x2_plus_y2.sv =====
// rk4_step_x2_plus_y2: one RK4 step for y' = x^2 + y^2 in signed fixed point
//
// A request (x_now, y_now) is taken at a rising edge with start high and busy
// low. busy stays low: the pipeline never stops, so one request per cycle is
// taken for as long as start is held. Each request gives one result on
// rsp_payload (x_next, y_next, overflow), marked by rsp_strobe for exactly one
// cycle. Requests stay in order.
// The 24 register stages are: the x + h/2 and x + h adders, four slope
// evaluations of two stages each (squares, then round and sum), three slope
// times step stages of two stages each, and nine stages for the weighted sum,
// its division by six and the final add to y. Multipliers each sit alone
// between two registers.
// The step size h is written through csr_write_enable / csr_write_data, by the
// user, only while no request is in flight; the block does not check this.
// Reset loads 0.2 and clears all valid bits, so no strobe comes out until a
// new request has gone through. The receiver cannot hold results off.
module rk4_step_x2_plus_y2 (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  rk4_pkg::req_payload_type      req_payload,
   output logic                          rsp_strobe,
   output rk4_pkg::rsp_payload_type      rsp_payload,
   input  logic                          csr_write_enable,
   input  logic [rk4_pkg::STEP_W-1:0]    csr_write_data
);
   import rk4_pkg::*;

   localparam scale_mode_type MODE_FIRST = '{half_step: 1'b1, double_weight: 1'b0};
   localparam scale_mode_type MODE_MID   = '{half_step: 1'b1, double_weight: 1'b1};
   localparam scale_mode_type MODE_LAST  = '{half_step: 1'b0, double_weight: 1'b1};

   logic [STEP_W-1:0]        step_ff, step_in;
   logic                     v0_ff, v0_in;
   logic signed [DATA_W-1:0] x0_ff, x0_in;
   ctx_type                  ctx0_ff, ctx0_in;
   sat_type                  xm_res, xe_res;

   logic                     s1_valid, s2_valid, s3_valid, s4_valid;
   ctx_type                  s1_ctx, s2_ctx, s3_ctx, s4_ctx;
   logic [SLOPE_W-1:0]       s1_m, s2_m, s3_m, s4_m;
   logic                     k1_valid, k2_valid, k3_valid;
   ctx_type                  k1_ctx, k2_ctx, k3_ctx;
   logic signed [DATA_W-1:0] k1_y, k2_y, k3_y;

   assign busy = 1'b0;

   always_comb begin
      step_in = csr_write_enable ? csr_write_data : step_ff;
   end

   always_comb begin
      xm_res = clamp_ext(EXT_W'(req_payload.x_now) + $signed(EXT_W'(step_ff >> 1)));
      xe_res = clamp_ext(EXT_W'(req_payload.x_now) + $signed(EXT_W'(step_ff)));
      v0_in  = start & ~busy;
      x0_in  = req_payload.x_now;
      ctx0_in.x_mid  = $signed(xm_res.value);
      ctx0_in.x_end  = $signed(xe_res.value);
      ctx0_in.y_base = req_payload.y_now;
      ctx0_in.acc    = '0;
      ctx0_in.ovf    = xm_res.sat | xe_res.sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_RESET;
         v0_ff   <= 1'b0;
      end else begin
         step_ff <= step_in;
         v0_ff   <= v0_in;
      end
   end

   always_ff @(posedge clock) begin
      x0_ff   <= x0_in;
      ctx0_ff <= ctx0_in;
   end

   rk4_slope u_slope1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v0_ff),
      .in_ctx    (ctx0_ff),
      .x_arg     (x0_ff),
      .y_arg     (ctx0_ff.y_base),
      .out_valid (s1_valid),
      .out_ctx   (s1_ctx),
      .slope_m   (s1_m)
   );

   rk4_scale u_scale1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ctx    (s1_ctx),
      .slope_m   (s1_m),
      .step_size (step_ff),
      .mode      (MODE_FIRST),
      .out_valid (k1_valid),
      .out_ctx   (k1_ctx),
      .y_arg     (k1_y)
   );

   rk4_slope u_slope2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (k1_valid),
      .in_ctx    (k1_ctx),
      .x_arg     (k1_ctx.x_mid),
      .y_arg     (k1_y),
      .out_valid (s2_valid),
      .out_ctx   (s2_ctx),
      .slope_m   (s2_m)
   );

   rk4_scale u_scale2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ctx    (s2_ctx),
      .slope_m   (s2_m),
      .step_size (step_ff),
      .mode      (MODE_MID),
      .out_valid (k2_valid),
      .out_ctx   (k2_ctx),
      .y_arg     (k2_y)
   );

   rk4_slope u_slope3 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (k2_valid),
      .in_ctx    (k2_ctx),
      .x_arg     (k2_ctx.x_mid),
      .y_arg     (k2_y),
      .out_valid (s3_valid),
      .out_ctx   (s3_ctx),
      .slope_m   (s3_m)
   );

   rk4_scale u_scale3 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid),
      .in_ctx    (s3_ctx),
      .slope_m   (s3_m),
      .step_size (step_ff),
      .mode      (MODE_LAST),
      .out_valid (k3_valid),
      .out_ctx   (k3_ctx),
      .y_arg     (k3_y)
   );

   rk4_slope u_slope4 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (k3_valid),
      .in_ctx    (k3_ctx),
      .x_arg     (k3_ctx.x_end),
      .y_arg     (k3_y),
      .out_valid (s4_valid),
      .out_ctx   (s4_ctx),
      .slope_m   (s4_m)
   );

   rk4_incr u_incr (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s4_valid),
      .in_ctx      (s4_ctx),
      .slope_m     (s4_m),
      .step_size   (step_ff),
      .out_valid   (rsp_strobe),
      .out_payload (rsp_payload)
   );

endmodule
